// File: hdl/ps2_mouse_cursor_tracker_macros.svh
// Assertion macros for the PS/2 mouse cursor tracker.
// Used by the top level; the macros expand to nothing when SYNTHESIS is defined.
`ifndef PS2_MOUSE_CURSOR_TRACKER_MACROS_SVH
`define PS2_MOUSE_CURSOR_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset
`define PMCT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pmct check failed");
// Next-cycle implication
`define PMCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pmct check failed");
`else
`define PMCT_ASSERT_NOW(label, clk, rst, ante, cons)
`define PMCT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hdl/pmct_pkg.sv
// Shared types and constants of the PS/2 mouse cursor tracker.
// No dependencies; used by the channel interface users and the top level.
`timescale 1ns / 1ps

package pmct_pkg;

  localparam int unsigned PosW  = 7;
  localparam int unsigned ByteW = 8;
  localparam int unsigned IdxW  = 2;

  // Header byte bits
  localparam int unsigned HdrSyncBit = 3;
  localparam int unsigned HdrOvfXBit = 6;
  localparam int unsigned HdrOvfYBit = 7;

  // Register reset values
  localparam logic [PosW-1:0] MaxXReset = 7'd79;
  localparam logic [PosW-1:0] MaxYReset = 7'd24;

  // Configuration register indexes
  localparam logic [IdxW-1:0] REG_MAX_X = 2'd0;
  localparam logic [IdxW-1:0] REG_MAX_Y = 2'd1;

  // Packet byte position, one-hot
  typedef enum logic [2:0] {
    PH_HEAD = 3'b001,
    PH_DX   = 3'b010,
    PH_DY   = 3'b100
  } phase_t;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
  } byte_req_t;

  typedef struct packed {
    logic [PosW-1:0] cursor_x;
    logic [PosW-1:0] cursor_y;
    logic            packet_dropped;
  } cursor_req_t;

endpackage

// File: hdl/pmct_chan_if.sv
// Valid/ready channel carrying one request payload of a chosen type.
// Depends on nothing; payload types come from pmct_pkg at the instance.
`timescale 1ns / 1ps

interface pmct_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/ps2_mouse_cursor_tracker.sv
// Top level of the PS/2 mouse cursor tracker: packet framing, cursor update, result register.
// Depends on pmct_pkg, pmct_chan_if and ps2_mouse_cursor_tracker_macros.svh.
`timescale 1ns / 1ps
`include "ps2_mouse_cursor_tracker_macros.svh"

// Takes one mouse byte per cycle and frames three-byte packets: a byte with bit 3 set opens
// a packet, other bytes between packets are dropped. The third byte of a packet moves the
// cursor by half the signed x and minus half the signed y movement, clamped to 0..max_x and
// 0..max_y, unless an overflow bit of the header is set; the result appears on the results
// channel in the cycle after the third byte is taken. The byte channel accepts a byte every
// cycle; it holds off only a third byte that arrives while the previous cursor request is
// still waiting in the single result register. Write max_x (index 0) and max_y (index 1)
// only while no packet is in flight.
module ps2_mouse_cursor_tracker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pmct_pkg::IdxW-1:0]        cfg_index,
  input  logic [pmct_pkg::PosW-1:0]        cfg_data,
  pmct_chan_if.sink                        bytes,
  pmct_chan_if.source                      results
);

  // Configuration registers
  logic [pmct_pkg::PosW-1:0] max_x;
  logic [pmct_pkg::PosW-1:0] max_y;

  // Packet state
  pmct_pkg::phase_t           phase;
  pmct_pkg::phase_t           phase_next;
  logic                       hdr_ovf;
  logic [pmct_pkg::ByteW-1:0] dx_byte;
  logic [pmct_pkg::PosW-1:0]  pos_x;
  logic [pmct_pkg::PosW-1:0]  pos_y;
  logic [pmct_pkg::PosW-1:0]  pos_x_next;
  logic [pmct_pkg::PosW-1:0]  pos_y_next;

  // Result register
  logic                  out_valid;
  pmct_pkg::cursor_req_t out_req;

  logic [pmct_pkg::ByteW-1:0] rx;
  logic                       in_fire;
  logic                       last_fire;
  logic signed [6:0]          half_dx;
  logic signed [6:0]          half_dy;
  logic signed [8:0]          sum_x;
  logic signed [8:0]          sum_y;

  assign rx        = bytes.payload.rx_byte;
  // Hold off only the closing byte while an unread result occupies the output
  assign bytes.ready = (phase != pmct_pkg::PH_DY) || !out_valid || results.ready;
  assign in_fire   = bytes.valid && bytes.ready;
  assign last_fire = in_fire && (phase == pmct_pkg::PH_DY);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_x <= pmct_pkg::MaxXReset;
      max_y <= pmct_pkg::MaxYReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pmct_pkg::REG_MAX_X: max_x <= cfg_data;
        pmct_pkg::REG_MAX_Y: max_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance packet framing
  always_comb begin
    unique case (phase)
      pmct_pkg::PH_DX: phase_next = pmct_pkg::PH_DY;
      pmct_pkg::PH_DY: phase_next = pmct_pkg::PH_HEAD;
      default:         phase_next = rx[pmct_pkg::HdrSyncBit] ? pmct_pkg::PH_DX
                                                             : pmct_pkg::PH_HEAD;
    endcase
  end

  // Halve signed movements, rounding toward zero
  always_comb begin
    half_dx = 7'((signed'(dx_byte) + 8'(dx_byte[7])) >>> 1);
    half_dy = 7'((signed'(rx) + 8'(rx[7])) >>> 1);
    sum_x   = signed'({2'b00, pos_x}) + 9'(half_dx);
    sum_y   = signed'({2'b00, pos_y}) - 9'(half_dy);
  end

  // Clamp the new position; keep it when the packet overflowed
  always_comb begin
    pos_x_next = pos_x;
    pos_y_next = pos_y;
    if (!hdr_ovf) begin
      if (sum_x < 0) begin
        pos_x_next = '0;
      end else if (sum_x > signed'({2'b00, max_x})) begin
        pos_x_next = max_x;
      end else begin
        pos_x_next = sum_x[pmct_pkg::PosW-1:0];
      end
      if (sum_y < 0) begin
        pos_y_next = '0;
      end else if (sum_y > signed'({2'b00, max_y})) begin
        pos_y_next = max_y;
      end else begin
        pos_y_next = sum_y[pmct_pkg::PosW-1:0];
      end
    end
  end

  // Update packet state and cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= pmct_pkg::PH_HEAD;
      hdr_ovf <= 1'b0;
      dx_byte <= '0;
      pos_x   <= '0;
      pos_y   <= '0;
    end else if (in_fire) begin
      phase <= phase_next;
      unique case (phase)
        pmct_pkg::PH_DX: dx_byte <= rx;
        pmct_pkg::PH_DY: begin
          pos_x <= pos_x_next;
          pos_y <= pos_y_next;
        end
        default: hdr_ovf <= rx[pmct_pkg::HdrOvfXBit] | rx[pmct_pkg::HdrOvfYBit];
      endcase
    end
  end

  // Load the result register on the closing byte, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (last_fire) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (last_fire) begin
      out_req.cursor_x       <= pos_x_next;
      out_req.cursor_y       <= pos_y_next;
      out_req.packet_dropped <= hdr_ovf;
    end
  end

  assign results.valid   = out_valid;
  assign results.payload = out_req;

  // Checks
  `PMCT_ASSERT_NEXT(a_pos_only_on_close, clk, rst, !last_fire,
                    $stable(pos_x) && $stable(pos_y))
  `PMCT_ASSERT_NOW(a_result_from_close, clk, rst, $rose(out_valid), $past(last_fire))
  `PMCT_ASSERT_NEXT(a_result_matches_pos, clk, rst, last_fire,
                    out_valid && out_req.cursor_x == pos_x && out_req.cursor_y == pos_y)

endmodule

// File: verif/ps2_mouse_cursor_tracker_tb.sv
// Testbench for ps2_mouse_cursor_tracker: feeds mouse bytes, predicts each cursor request.
// Depends on pmct_pkg, pmct_chan_if and the ps2_mouse_cursor_tracker RTL.
`timescale 1ns / 1ps

module ps2_mouse_cursor_tracker_tb;

  typedef logic [pmct_pkg::ByteW-1:0] byte_t;
  typedef logic [pmct_pkg::PosW-1:0]  pos_t;

  // Register indexes the block does not decode; writes there must be ignored
  localparam logic [pmct_pkg::IdxW-1:0] REG_SPARE_A = 2'd2;
  localparam logic [pmct_pkg::IdxW-1:0] REG_SPARE_B = 2'd3;
  localparam int PhaseCount = 8;
  localparam int BytesPerPhase = 100;

  // Tracks the cursor and holds the cursor requests still due from the block
  class cursor_scoreboard;
    pos_t                  max_x = pmct_pkg::MaxXReset;
    pos_t                  max_y = pmct_pkg::MaxYReset;
    pmct_pkg::phase_t      phase = pmct_pkg::PH_HEAD;
    byte_t                 header = '0;
    byte_t                 dx = '0;
    pos_t                  pos_x = '0;
    pos_t                  pos_y = '0;
    pmct_pkg::cursor_req_t cursor_due_q[$];
    int unsigned           mismatches = 0;

    function int half_move(byte_t b);
      return int'($signed(b)) / 2;
    endfunction

    function pos_t clamp_to(int v, pos_t hi);
      if (v < 0) return '0;
      if (v > int'(hi)) return hi;
      return v[pmct_pkg::PosW-1:0];
    endfunction

    function void set_limit(logic [pmct_pkg::IdxW-1:0] idx, pos_t val);
      if (idx == pmct_pkg::REG_MAX_X) max_x = val;
      else if (idx == pmct_pkg::REG_MAX_Y) max_y = val;
    endfunction

    function int pending();
      return cursor_due_q.size();
    endfunction

    // Advance the packet framing by one accepted byte
    function void note_byte(byte_t b);
      pmct_pkg::cursor_req_t due;
      logic dropped;
      case (phase)
        pmct_pkg::PH_DX: begin
          dx = b;
          phase = pmct_pkg::PH_DY;
        end
        pmct_pkg::PH_DY: begin
          phase = pmct_pkg::PH_HEAD;
          dropped = header[pmct_pkg::HdrOvfXBit] | header[pmct_pkg::HdrOvfYBit];
          if (!dropped) begin
            pos_x = clamp_to(int'(pos_x) + half_move(dx), max_x);
            pos_y = clamp_to(int'(pos_y) - half_move(b), max_y);
          end
          due.cursor_x = pos_x;
          due.cursor_y = pos_y;
          due.packet_dropped = dropped;
          cursor_due_q.push_back(due);
        end
        default: begin
          header = b;
          phase = b[pmct_pkg::HdrSyncBit] ? pmct_pkg::PH_DX : pmct_pkg::PH_HEAD;
        end
      endcase
    endfunction

    function void check_cursor(pmct_pkg::cursor_req_t got);
      pmct_pkg::cursor_req_t want;
      if (cursor_due_q.size() == 0) begin
        $error("cursor request with none due: x=%0d y=%0d dropped=%0b",
               got.cursor_x, got.cursor_y, got.packet_dropped);
        mismatches++;
        return;
      end
      want = cursor_due_q.pop_front();
      if (got.cursor_x !== want.cursor_x) begin
        $error("cursor_x: expected %0d, got %0d", want.cursor_x, got.cursor_x);
        mismatches++;
      end
      if (got.cursor_y !== want.cursor_y) begin
        $error("cursor_y: expected %0d, got %0d", want.cursor_y, got.cursor_y);
        mismatches++;
      end
      if (got.packet_dropped !== want.packet_dropped) begin
        $error("packet_dropped: expected %0b, got %0b",
               want.packet_dropped, got.packet_dropped);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [pmct_pkg::IdxW-1:0] cfg_index;
  pos_t cfg_data;
  logic calm;
  int unsigned bytes_sent;
  cursor_scoreboard sb;

  pmct_chan_if #(.payload_t(pmct_pkg::byte_req_t))   byte_ch ();
  pmct_chan_if #(.payload_t(pmct_pkg::cursor_req_t)) res_ch ();

  ps2_mouse_cursor_tracker uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .bytes     (byte_ch),
    .results   (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side at random unless in the calm stretch
  always @(posedge clk) begin
    res_ch.ready <= calm || ($urandom_range(0, 99) >= 23);
  end

  // Check every accepted cursor request
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) sb.check_cursor(res_ch.payload);
  end

  // Offer one byte, with a random gap first, and hold it until taken
  task automatic send_byte(input byte_t b);
    while (!calm && $urandom_range(0, 99) < 23) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.payload.rx_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_packet(input byte_t hdr, input byte_t mx, input byte_t my);
    send_byte(hdr);
    send_byte(mx);
    send_byte(my);
  endtask

  // Finish any open packet so the block is idle
  task automatic close_packet();
    while (sb.phase != pmct_pkg::PH_HEAD) send_byte(byte_t'($urandom));
  endtask

  // Drop valid and wait for every cursor request due, plus the result latency
  task automatic settle();
    byte_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both limits and one undecoded index while idle
  task automatic write_limits(input pos_t mx, input pos_t my);
    pos_t junk;
    junk = pos_t'($urandom);
    cfg_we <= 1'b1;
    cfg_index <= pmct_pkg::REG_MAX_X;
    cfg_data <= mx;
    @(posedge clk);
    sb.set_limit(pmct_pkg::REG_MAX_X, mx);
    cfg_index <= pmct_pkg::REG_MAX_Y;
    cfg_data <= my;
    @(posedge clk);
    sb.set_limit(pmct_pkg::REG_MAX_Y, my);
    cfg_index <= $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B;
    cfg_data <= junk;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed packets with random content, some noise and reframing
  task automatic send_random_traffic(input int unsigned count);
    byte_t hdr;
    int unsigned stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 99) < 10) begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1)) send_byte(byte_t'($urandom));
          else send_byte(byte_t'($urandom) & ~(byte_t'(1) << pmct_pkg::HdrSyncBit));
        end
      end
      hdr = byte_t'($urandom);
      hdr[pmct_pkg::HdrSyncBit] = 1'b1;
      if ($urandom_range(0, 99) >= 15) begin
        hdr[pmct_pkg::HdrOvfXBit] = 1'b0;
        hdr[pmct_pkg::HdrOvfYBit] = 1'b0;
      end
      send_packet(hdr, byte_t'($urandom), byte_t'($urandom));
    end
  endtask

  initial begin
    pos_t lim_x[PhaseCount];
    pos_t lim_y[PhaseCount];
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = pmct_pkg::REG_MAX_X;
    cfg_data = '0;
    byte_ch.valid = 1'b0;
    byte_ch.payload = '0;
    res_ch.ready = 1'b0;
    calm = 1'b0;
    bytes_sent = 0;
    lim_x = '{pmct_pkg::MaxXReset, 7'd127, 7'd0, 7'd127, 7'd0, 7'd0, 7'd5, 7'd127};
    lim_y = '{pmct_pkg::MaxYReset, 7'd127, 7'd0, 7'd0, 7'd127, 7'd0, 7'd100, 7'd3};
    lim_x[5] = pos_t'($urandom_range(0, 127));
    lim_y[5] = pos_t'($urandom_range(0, 127));
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: framing, extreme moves, truncation, overflow drops, reset limits
    send_byte(8'h00);
    send_byte(8'hF7);
    send_packet(8'h08, 8'h7F, 8'h80);
    send_packet(8'h3F, 8'h7F, 8'h7F);
    send_packet(8'h08, 8'hFF, 8'h01);
    send_packet(8'h18, 8'h80, 8'hFF);
    send_packet(8'hC8, 8'h10, 8'h10);
    send_packet(8'h48, 8'h7F, 8'h80);
    send_packet(8'h88, 8'h80, 8'h7F);
    settle();

    for (int p = 0; p < PhaseCount; p++) begin
      if (p > 0) write_limits(lim_x[p], lim_y[p]);
      calm = (p == 3);
      send_random_traffic(BytesPerPhase);
      close_packet();
      settle();
    end
    calm = 1'b0;

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ps2_mouse_cursor_tracker_tb: PASS");
    end else begin
      $display("ps2_mouse_cursor_tracker_tb: FAIL");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #2_000_000;
    $display("ps2_mouse_cursor_tracker_tb: FAIL");
    $finish;
  end

endmodule
